FILE: sv/elft_pkg.sv
package elft_pkg;

  // Number of frames the order can hold, and the widths that follow from it.
  localparam int NUM_FRAMES = 64;
  localparam int OCC_W      = $clog2(NUM_FRAMES + 1);
  localparam int FRAME_W    = 6;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [OCC_W-1:0]   occ_t;

  typedef enum logic {
    CMD_REFERENCE = 1'b0,
    CMD_EVICT     = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_REFERENCED = 2'd0,
    ST_EVICTED    = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // Per-cell control; upd and evict are shared by every cell of the row, valid is per cell.
  typedef struct packed {
    logic upd;    // the pending item is applied at this edge
    logic evict;  // the pending item is an evict
    logic valid;  // this cell lies below the fill count
  } cell_ctrl_t;

endpackage

FILE: sv/elft_cell.sv
module elft_cell (
  input  logic                clk,
  input  elft_pkg::cell_ctrl_t ctrl,
  input  elft_pkg::frame_t    frame,
  input  elft_pkg::frame_t    up_value,
  input  logic                shift_in,
  input  logic                load,
  output elft_pkg::frame_t    value,
  output logic                shift_out
);

  logic hit;
  elft_pkg::frame_t value_next;

  // A reference that matches here starts the shift for this cell and all above it.
  assign hit       = ctrl.valid && !ctrl.evict && (value == frame);
  assign shift_out = shift_in || hit;

  always_comb begin
    value_next = value;
    if (load) begin
      value_next = frame;
    end else if (shift_out) begin
      value_next = up_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      value <= value_next;
    end
  end

endmodule

FILE: sv/exact_lru_frame_tracker.sv
// Exact LRU tracker for physical page frames, built as a row of compare-and-shift
// cells. Cell 0 holds the least recently used frame; the fill count marks how many
// cells are in use.
//
// Input beats on s_*: s_tuser is the command (reference or evict), s_tdata carries
// the frame number. Every input beat yields exactly one output beat on m_*, with
// the victim frame in m_tdata and the status code in m_tuser.
//
// An accepted beat is held in a one-entry command register; once the output side is
// free, every cell compares its frame with it, the match position ripples up the
// row as a shift enable, all cells update together and the result lands in the
// output register, which raises m_tvalid. The block takes one beat per cycle as
// long as the output side keeps up.
//
// When the receiver stalls, the result waits in the output register and the
// pending command waits in its register; s_tready drops once both are full.
// Reset empties the order (the fill count goes to zero) and clears both valid
// flags; the cell contents are left as they are and are never read before written.
module exact_lru_frame_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [5:0] frame_number, [7:6] zero
  input  logic       s_tuser,   // [0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] victim_frame, [7:6] zero
  output logic [1:0] m_tuser    // [1:0] status
);

  localparam int N = elft_pkg::NUM_FRAMES;

  // Pending command register.
  logic             busy;
  elft_pkg::cmd_t   cmd;
  elft_pkg::frame_t frame;

  // Fill count of the order.
  elft_pkg::occ_t   occ;
  elft_pkg::occ_t   occ_next;
  elft_pkg::occ_t   tail;

  logic             out_free;
  logic             upd;
  logic             evict;
  logic             found;

  elft_pkg::frame_t   cell_value [N];
  elft_pkg::frame_t   cell_up    [N];
  logic [N:0]         shift_chain;
  logic [N-1:0]       cell_load;
  elft_pkg::cell_ctrl_t cell_ctrl [N];

  elft_pkg::status_t  status_next;
  elft_pkg::frame_t   victim_next;
  elft_pkg::status_t  status;
  elft_pkg::frame_t   victim;

  assign out_free = !m_tvalid || m_tready;
  assign upd      = busy && out_free;
  assign s_tready = !busy || out_free;
  assign evict    = (cmd == elft_pkg::CMD_EVICT);
  assign tail     = occ - elft_pkg::occ_t'(1);

  // An evict shifts the whole row down; a reference starts the shift at its match.
  assign shift_chain[0] = evict;
  assign found          = !evict && shift_chain[N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam elft_pkg::occ_t IDX = elft_pkg::occ_t'(g);

    if (g == N - 1) begin : g_top
      assign cell_up[g] = '0;
    end else begin : g_mid
      assign cell_up[g] = cell_value[g+1];
    end

    assign cell_ctrl[g] = '{upd: upd, evict: evict, valid: (IDX < occ)};

    // A hit places the frame at the current tail; a miss appends one past it.
    assign cell_load[g] = !evict && (found ? (IDX == tail) : (IDX == occ));

    elft_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .frame     (frame),
      .up_value  (cell_up[g]),
      .shift_in  (shift_chain[g]),
      .load      (cell_load[g]),
      .value     (cell_value[g]),
      .shift_out (shift_chain[g+1])
    );
  end

  always_comb begin
    occ_next    = occ;
    victim_next = '0;
    status_next = elft_pkg::ST_REFERENCED;
    if (evict) begin
      if (occ == '0) begin
        status_next = elft_pkg::ST_EMPTY;
      end else begin
        status_next = elft_pkg::ST_EVICTED;
        victim_next = cell_value[0];
        occ_next    = occ - elft_pkg::occ_t'(1);
      end
    end else if (!found) begin
      if (occ == elft_pkg::occ_t'(N)) begin
        status_next = elft_pkg::ST_FULL;
      end else begin
        occ_next = occ + elft_pkg::occ_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      occ      <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
      end else if (upd) begin
        busy <= 1'b0;
      end
      if (upd) begin
        m_tvalid <= 1'b1;
        occ      <= occ_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd   <= elft_pkg::cmd_t'(s_tuser);
      frame <= s_tdata[elft_pkg::FRAME_W-1:0];
    end
    if (upd) begin
      status <= status_next;
      victim <= victim_next;
    end
  end

  assign m_tdata = {2'b00, victim};
  assign m_tuser = status;

  // The fill count never passes the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= elft_pkg::occ_t'(N))
    else $error("fill count above capacity");

  // The victim field is zero unless the result is an eviction.
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != elft_pkg::ST_EVICTED) |-> (victim == '0))
    else $error("victim set on a non-evict result");

  // A full result is shown only while the order is full.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == elft_pkg::ST_FULL) |-> (occ == elft_pkg::occ_t'(N)))
    else $error("full status with free space");

  // An applied eviction from a non-empty order drops the count by one.
  a_evict_dec: assert property (@(posedge clk) disable iff (rst)
    (upd && evict && occ != '0) |=> (occ == $past(occ) - elft_pkg::occ_t'(1)))
    else $error("eviction did not shrink the order");

endmodule
